>>> hw/rtl/sfb_pkg.sv
// Shared types and constants of the serial frame builder.
package sfb_pkg;

    localparam logic [7:0] MAX_PAYLOAD = 8'd255;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_SOF_FIRST     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOF_SECOND    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_VERSION = 2'd2;

    localparam logic [7:0] SOF_FIRST_RESET     = 8'hAA;
    localparam logic [7:0] SOF_SECOND_RESET    = 8'h55;
    localparam logic [7:0] FRAME_VERSION_RESET = 8'h01;

    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    localparam logic [1:0] OP_ERROR = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_DATA  = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [7:0] msg_type;
        logic [7:0] data_len;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       error;
    } out_word_t;

    typedef struct packed {
        logic [7:0] sof_first;
        logic [7:0] sof_second;
        logic [7:0] frame_version;
    } cfg_t;

    typedef struct packed {
        logic [1:0] op;
        logic       with_crc;
        logic [7:0] b0;
        logic [7:0] b1;
    } cmd_t;

endpackage

>>> hw/rtl/serial_frame_builder_crc16_top.sv
// Top level of the serial frame builder with CRC-16/CCITT-FALSE.
// An accepted word's first byte passes the command queue, then the result register.
// Throughput: one word is accepted per cycle while the command queue has room.
// The emitter makes a byte per cycle unless a result waits; start words make 5 or 7 bytes.
// Reset clears the queue, the open frame and the result register, seeds the CRC with 0xFFFF,
// and loads the start-of-frame bytes 0xAA, 0x55 and the version 0x01.
module serial_frame_builder_crc16_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  sfb_pkg::in_word_t                    item,
    output logic                                 empty,
    input  logic                                 pop,
    output sfb_pkg::out_word_t                   result,
    input  logic                                 cfg_we,
    input  logic [sfb_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [7:0]                           cfg_data
);
    import sfb_pkg::*;

    cfg_t cfg_reg;
    cmd_t front_cmd;
    cmd_t queue_cmd;
    logic accept;
    logic q_empty;
    logic q_pop;
    logic result_valid;

    assign accept = push && !full;
    assign empty  = !result_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sof_first     <= SOF_FIRST_RESET;
            cfg_reg.sof_second    <= SOF_SECOND_RESET;
            cfg_reg.frame_version <= FRAME_VERSION_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SOF_FIRST:     cfg_reg.sof_first     <= cfg_data;
                REG_SOF_SECOND:    cfg_reg.sof_second    <= cfg_data;
                REG_FRAME_VERSION: cfg_reg.frame_version <= cfg_data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    sfb_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cmd    (front_cmd)
    );

    sfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept),
        .wr_cmd (front_cmd),
        .full   (full),
        .rd_en  (q_pop),
        .rd_cmd (queue_cmd),
        .empty  (q_empty)
    );

    sfb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd          (queue_cmd),
        .cmd_empty    (q_empty),
        .cmd_pop      (q_pop),
        .result       (result),
        .result_valid (result_valid),
        .result_take  (pop && result_valid)
    );

endmodule

>>> hw/rtl/sfb_front.sv
// Front end: accepts words, tracks the open frame and issues frame commands.
module sfb_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  sfb_pkg::in_word_t item,
    output sfb_pkg::cmd_t     cmd
);
    import sfb_pkg::*;

    logic       frame_open_reg;
    logic       frame_open_next;
    logic [7:0] bytes_left_reg;
    logic [7:0] bytes_left_next;

    always_comb
    begin
        frame_open_next = frame_open_reg;
        bytes_left_next = bytes_left_reg;
        cmd.op          = OP_ERROR;
        cmd.with_crc    = 1'b0;
        cmd.b0          = item.data_byte;
        cmd.b1          = item.data_len;
        if (item.kind == KIND_START)
        begin
            if (item.data_len > MAX_PAYLOAD)
            begin
                frame_open_next = 1'b0;
                bytes_left_next = 8'd0;
            end
            else
            begin
                cmd.op          = OP_START;
                cmd.b0          = item.msg_type;
                cmd.with_crc    = (item.data_len == 8'd0);
                frame_open_next = (item.data_len != 8'd0);
                bytes_left_next = item.data_len;
            end
        end
        else if (frame_open_reg)
        begin
            cmd.op          = OP_DATA;
            cmd.with_crc    = (bytes_left_reg == 8'd1);
            bytes_left_next = bytes_left_reg - 8'd1;
            frame_open_next = (bytes_left_reg != 8'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            bytes_left_reg <= 8'd0;
        end
        else if (accept)
        begin
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

>>> hw/rtl/sfb_queue.sv
// Command queue between the front end and the byte emitter.
module sfb_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  sfb_pkg::cmd_t wr_cmd,
    output logic          full,
    input  logic          rd_en,
    output sfb_pkg::cmd_t rd_cmd,
    output logic          empty
);
    import sfb_pkg::*;

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] FULL_CNT  = COUNT_W'(DEPTH);

    cmd_t               entries [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               do_wr;
    logic               do_rd;

    assign full   = (count_reg == FULL_CNT);
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_cmd = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - COUNT_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("Queue count exceeds its depth.");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !rd_en) |=> full)
        else $error("Queue left the full state without a read.");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == FULL_CNT) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("Queue pointers disagree with the count.");

endmodule

>>> hw/rtl/sfb_back.sv
// Back end: expands frame commands into bytes, keeps the CRC and the result register.
module sfb_back (
    input  logic               clk,
    input  logic               rst_n,
    input  sfb_pkg::cfg_t      cfg,
    input  sfb_pkg::cmd_t      cmd,
    input  logic               cmd_empty,
    output logic               cmd_pop,
    output sfb_pkg::out_word_t result,
    output logic               result_valid,
    input  logic               result_take
);
    import sfb_pkg::*;

    localparam logic [15:0] CRC_SEED = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    logic [2:0]  step_reg;
    logic [15:0] crc_reg;
    logic        valid_reg;
    out_word_t   result_reg;

    logic        adv;
    logic        final_step;
    logic        crc_update;
    logic [15:0] crc_base;
    out_word_t   word_next;
    logic [2:0]  crc_step;

    assign adv          = !cmd_empty && (!valid_reg || result_take);
    assign cmd_pop      = adv && final_step;
    assign result       = result_reg;
    assign result_valid = valid_reg;

    always_comb
    begin
        word_next.out_byte = 8'd0;
        word_next.last     = 1'b0;
        word_next.error    = 1'b0;
        final_step         = 1'b1;
        crc_update         = 1'b0;
        crc_base           = crc_reg;
        crc_step           = 3'd1;
        case (cmd.op)
            OP_START:
            begin
                crc_step   = 3'd5;
                final_step = (step_reg == (cmd.with_crc ? 3'd6 : 3'd4));
                case (step_reg)
                    3'd0: word_next.out_byte = cfg.sof_first;
                    3'd1: word_next.out_byte = cfg.sof_second;
                    3'd2:
                    begin
                        word_next.out_byte = cfg.frame_version;
                        crc_update         = 1'b1;
                        crc_base           = CRC_SEED;
                    end
                    3'd3:
                    begin
                        word_next.out_byte = cmd.b0;
                        crc_update         = 1'b1;
                    end
                    3'd4:
                    begin
                        word_next.out_byte = cmd.b1;
                        crc_update         = 1'b1;
                    end
                    default: word_next.out_byte = 8'd0;
                endcase
            end
            OP_DATA:
            begin
                crc_step   = 3'd1;
                final_step = (step_reg == (cmd.with_crc ? 3'd2 : 3'd0));
                if (step_reg == 3'd0)
                begin
                    word_next.out_byte = cmd.b0;
                    crc_update         = 1'b1;
                end
            end
            default:
            begin
                word_next.last  = 1'b1;
                word_next.error = 1'b1;
            end
        endcase
        if (cmd.op != OP_ERROR)
        begin
            if (step_reg == crc_step)
            begin
                word_next.out_byte = crc_reg[7:0];
            end
            else if (step_reg == crc_step + 3'd1)
            begin
                word_next.out_byte = crc_reg[15:8];
                word_next.last     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= word_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 3'd0;
            crc_reg   <= CRC_SEED;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                valid_reg <= 1'b1;
                step_reg  <= final_step ? 3'd0 : step_reg + 3'd1;
                if (crc_update)
                begin
                    crc_reg <= crc_byte(crc_base, word_next.out_byte);
                end
            end
            else if (result_take)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && result_reg.error) |-> result_reg.last)
        else $error("Error word was not marked last.");

    a_pop_ends_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (step_reg == 3'd0))
        else $error("Command left the queue in the middle of a frame.");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !result_take) |=> (valid_reg && $stable(result_reg)))
        else $error("Waiting result word changed before it was taken.");

endmodule

>>> dv/sfb_frame_checker.sv
// Frame byte predictor and scoreboard for the serial frame builder testbench.
module sfb_frame_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic                                 full,
    input  sfb_pkg::in_word_t                    item,
    input  logic                                 empty,
    input  logic                                 pop,
    input  sfb_pkg::out_word_t                   result,
    input  logic                                 cfg_we,
    input  logic [sfb_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [7:0]                           cfg_data,
    output int                                   mismatch_count,
    output int                                   outstanding,
    output int                                   words_in,
    output int                                   bytes_out,
    output int                                   frames_done,
    output int                                   error_bytes,
    output int                                   stall_cycles
);
    timeunit 1ns;
    timeprecision 1ps;
    import sfb_pkg::*;

    localparam logic [15:0] CRC_SEED = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    logic [7:0]  sof_first_q;
    logic [7:0]  sof_second_q;
    logic [7:0]  version_q;
    logic [15:0] running_crc;
    logic [7:0]  payload_left;
    logic        frame_is_open;

    out_word_t frame_bytes_due[$];

    function automatic logic [15:0] crc16_ccitt(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    task automatic add_due(input logic [7:0] b, input logic is_last, input logic is_error);
        out_word_t w;
        w.out_byte = b;
        w.last     = is_last;
        w.error    = is_error;
        frame_bytes_due.push_back(w);
    endtask

    task automatic close_frame();
        add_due(running_crc[7:0], 1'b0, 1'b0);
        add_due(running_crc[15:8], 1'b1, 1'b0);
        running_crc   = CRC_SEED;
        payload_left  = '0;
        frame_is_open = 1'b0;
    endtask

    task automatic predict_frame_bytes(input in_word_t w);
        if (w.kind == KIND_START)
        begin
            if (w.data_len > MAX_PAYLOAD)
            begin
                running_crc   = CRC_SEED;
                payload_left  = '0;
                frame_is_open = 1'b0;
                add_due(8'h00, 1'b1, 1'b1);
            end
            else
            begin
                add_due(sof_first_q, 1'b0, 1'b0);
                add_due(sof_second_q, 1'b0, 1'b0);
                add_due(version_q, 1'b0, 1'b0);
                add_due(w.msg_type, 1'b0, 1'b0);
                add_due(w.data_len, 1'b0, 1'b0);
                running_crc = crc16_ccitt(CRC_SEED, version_q);
                running_crc = crc16_ccitt(running_crc, w.msg_type);
                running_crc = crc16_ccitt(running_crc, w.data_len);
                if (w.data_len == 8'd0)
                begin
                    close_frame();
                end
                else
                begin
                    payload_left  = w.data_len;
                    frame_is_open = 1'b1;
                end
            end
        end
        else if (!frame_is_open)
        begin
            add_due(8'h00, 1'b1, 1'b1);
        end
        else
        begin
            add_due(w.data_byte, 1'b0, 1'b0);
            running_crc  = crc16_ccitt(running_crc, w.data_byte);
            payload_left = payload_left - 8'd1;
            if (payload_left == 8'd0)
            begin
                close_frame();
            end
        end
    endtask

    task automatic check_byte(input out_word_t got);
        out_word_t want;
        bytes_out++;
        if (frame_bytes_due.size() == 0)
        begin
            $error("unexpected result word: out_byte %0h last %0b error %0b",
                   got.out_byte, got.last, got.error);
            mismatch_count++;
        end
        else
        begin
            want = frame_bytes_due.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
                mismatch_count++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                mismatch_count++;
            end
            if (got.error !== want.error)
            begin
                $error("error: expected %0b, actual %0b", want.error, got.error);
                mismatch_count++;
            end
            if (want.last && !want.error)
            begin
                frames_done++;
            end
            if (want.error)
            begin
                error_bytes++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sof_first_q    = SOF_FIRST_RESET;
            sof_second_q   = SOF_SECOND_RESET;
            version_q      = FRAME_VERSION_RESET;
            running_crc    = CRC_SEED;
            payload_left   = '0;
            frame_is_open  = 1'b0;
            frame_bytes_due.delete();
            mismatch_count = 0;
            outstanding    = 0;
            words_in       = 0;
            bytes_out      = 0;
            frames_done    = 0;
            error_bytes    = 0;
            stall_cycles   = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SOF_FIRST:     sof_first_q  = cfg_data;
                    REG_SOF_SECOND:    sof_second_q = cfg_data;
                    REG_FRAME_VERSION: version_q    = cfg_data;
                    default: ;
                endcase
            end
            if (push && full)
            begin
                stall_cycles++;
            end
            if (push && !full)
            begin
                words_in++;
                predict_frame_bytes(item);
            end
            if (pop && !empty)
            begin
                check_byte(result);
            end
            outstanding = frame_bytes_due.size();
        end
    end

endmodule

>>> dv/serial_frame_builder_crc16_top_tb.sv
// Testbench top for the serial frame builder: stimulus, flow control and verdict.
module serial_frame_builder_crc16_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sfb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_WORDS  = 20;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 10;

    typedef enum int {RX_STREAM, RX_RANDOM, RX_PATTERN} rx_mode_t;

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    in_word_t               item;
    logic                   empty;
    logic                   pop;
    out_word_t              result;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]             cfg_data;

    int mismatch_count;
    int outstanding;
    int words_in;
    int bytes_out;
    int frames_done;
    int error_bytes;
    int stall_cycles;

    int       cycle_count  = 0;
    int       burst_left   = 0;
    bit       steady       = 1'b0;
    int       hold_seq     = 0;
    int       hold_seen    = 0;
    int       hold_left    = 0;
    rx_mode_t rx_mode      = RX_STREAM;
    int       rx_mode_left = 0;
    logic [7:0] rx_pattern = 8'hFF;

    serial_frame_builder_crc16_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sfb_frame_checker frame_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .item           (item),
        .empty          (empty),
        .pop            (pop),
        .result         (result),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .words_in       (words_in),
        .bytes_out      (bytes_out),
        .frames_done    (frames_done),
        .error_bytes    (error_bytes),
        .stall_cycles   (stall_cycles)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** serial_frame_builder_crc16_top: FAILED **");
            $finish;
        end
    end

    // The receiver switches between patterns on its own and honors long hold-off requests.
    always @(negedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (rx_mode_left == 0)
        begin
            rx_mode      = rx_mode_t'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(16, 96);
            rx_pattern   = 8'($urandom);
        end
        else
        begin
            rx_mode_left--;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_STREAM: pop <= 1'b1;
                RX_RANDOM: pop <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    pop <= rx_pattern[0];
                    rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
                end
            endcase
        end
    end

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
    endtask

    task automatic send_word(input in_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            gap = steady ? 0 : $urandom_range(0, 6);
            idle_cycles(gap);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        push <= 1'b1;
        item <= w;
        do @(posedge clk); while (full);
    endtask

    task automatic send_start(input logic [7:0] mtype, input logic [7:0] len);
        in_word_t w;
        w.kind      = KIND_START;
        w.msg_type  = mtype;
        w.data_len  = len;
        w.data_byte = 8'($urandom);
        send_word(w);
    endtask

    task automatic send_payload(input logic [7:0] b);
        in_word_t w;
        w.kind      = KIND_PAYLOAD;
        w.msg_type  = 8'($urandom);
        w.data_len  = 8'($urandom);
        w.data_byte = b;
        send_word(w);
    endtask

    task automatic settle();
        idle_cycles(1);
        wait (outstanding == 0);
        idle_cycles(DRAIN_CYCLES);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] first, input logic [7:0] second,
                              input logic [7:0] version);
        settle();
        write_cfg(REG_SOF_FIRST, first);
        write_cfg(REG_SOF_SECOND, second);
        write_cfg(REG_FRAME_VERSION, version);
    endtask

    // Mostly complete frames, some abandoned ones, and stray payload words.
    task automatic random_sequence();
        int pick;
        int len;
        int count;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            send_start(8'($urandom), 8'(len));
            repeat (len) send_payload(8'($urandom));
        end
        else if (pick < 85)
        begin
            len   = $urandom_range(1, 255);
            count = $urandom_range(0, (len - 1 < 5) ? len - 1 : 5);
            send_start(8'($urandom), 8'(len));
            repeat (count) send_payload(8'($urandom));
        end
        else
        begin
            send_payload(8'($urandom));
        end
    endtask

    initial
    begin
        int phase_start;
        rst_n     = 1'b0;
        push      = 1'b0;
        pop       = 1'b0;
        item      = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_SOF_FIRST;
        cfg_data  = 8'h00;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_payload(8'h00);
        send_payload(8'hFF);
        send_start(8'h00, 8'd0);
        send_start(8'hFF, 8'd0);
        send_start(8'h5A, 8'd1);
        send_payload(8'hFF);
        send_start(8'h3C, 8'd200);
        send_payload(8'h00);
        send_payload(8'h80);
        send_start(8'hC3, 8'd2);
        send_payload(8'h7F);
        send_payload(8'h01);
        send_payload(8'h55);
        send_start(8'h81, 8'd128);
        send_payload(8'hAA);
        send_start(8'h00, 8'd3);
        send_payload(8'h12);
        send_payload(8'hED);
        send_payload(8'h00);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       set_config(8'h00, 8'h00, 8'h00);
                1:       set_config(8'hFF, 8'hFF, 8'hFF);
                2:       set_config(8'($urandom), 8'($urandom), 8'($urandom));
                default: set_config(SOF_FIRST_RESET, SOF_SECOND_RESET, FRAME_VERSION_RESET);
            endcase
            if (phase == 0)
            begin
                steady = 1'b1;
                hold_seq++;
                repeat (10) random_sequence();
                steady = 1'b0;
            end
            if (phase == 1)
            begin
                send_start(8'($urandom), 8'd255);
                repeat (255) send_payload(8'($urandom));
            end
            phase_start = words_in;
            while (words_in - phase_start < PHASE_WORDS)
            begin
                random_sequence();
                if (phase == 2 && $urandom_range(0, 19) == 0)
                begin
                    idle_cycles(1);
                    wait (outstanding == 0);
                end
            end
        end

        settle();
        $display("Run covered %0d input words and %0d result bytes: %0d frames, %0d error bytes.",
                 words_in, bytes_out, frames_done, error_bytes);
        $display("Input was held off by a full queue for %0d cycles over %0d cycles.",
                 stall_cycles, cycle_count);
        if (mismatch_count == 0)
        begin
            $display("** serial_frame_builder_crc16_top: PASSED **");
        end
        else
        begin
            $display("** serial_frame_builder_crc16_top: FAILED **");
        end
        $finish;
    end

endmodule
